FILE: hw/rtl/bapsq_pkg.sv
// Shared types, constants and pattern tables for the buzzer alarm pattern sequencer.
package bapsq_pkg;

   localparam int PATTERN_LENGTH = 10;
   localparam int COUNTDOWN_BITS = 16;
   localparam int POS_W = (PATTERN_LENGTH > 1) ? $clog2(PATTERN_LENGTH) : 1;
   localparam int MINUTE_W = 11;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 11;
   localparam logic [COUNTDOWN_BITS-1:0] PIP_TICKS = COUNTDOWN_BITS'(2);

   localparam logic [CSR_INDEX_W-1:0] CSR_QUIET_START = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUIET_END = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FORCE_MUTE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALARM_EN = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WARNING_EN = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOUCH_EN = 3'd5;

   localparam logic [1:0] PAT_ALARM = 2'd0;
   localparam logic [1:0] PAT_LEVEL = 2'd1;
   localparam logic [1:0] PAT_FUEL = 2'd2;

   typedef struct packed {
      logic                hundred_ms_tick;
      logic [MINUTE_W-1:0] minute_of_day;
      logic                error_active;
      logic                level_high_warning;
      logic                low_fuel_warning;
      logic                touch_active;
   } req_payload_type;

   typedef struct packed {
      logic buzzer_drive;
      logic sound_enabled;
   } rsp_payload_type;

   typedef struct packed {
      logic [MINUTE_W-1:0] quiet_start_minute;
      logic [MINUTE_W-1:0] quiet_end_minute;
      logic                force_mute;
      logic                alarm_announce_enable;
      logic                warning_announce_enable;
      logic                touch_announce_enable;
   } csr_type;

   // One pattern step: restart marker, buzzer level and duration in ticks.
   typedef struct packed {
      logic                      restart;
      logic                      drive_on;
      logic [COUNTDOWN_BITS-1:0] ticks;
   } entry_type;

   localparam entry_type ENTRY_END = '{restart: 1'b1, drive_on: 1'b0, ticks: '0};

   function automatic entry_type make_entry(input logic on, input int unsigned ticks);
      entry_type e;
      e.restart = 1'b0;
      e.drive_on = on;
      e.ticks = COUNTDOWN_BITS'(ticks);
      return e;
   endfunction

   function automatic entry_type pattern_entry(input logic [1:0] sel,
                                               input logic [POS_W-1:0] pos);
      entry_type e;
      e = ENTRY_END;
      unique case (sel)
         PAT_ALARM: begin
            if (pos == POS_W'(0)) e = make_entry(1'b1, 50);
            else if (pos == POS_W'(1)) e = make_entry(1'b0, 50);
         end
         PAT_LEVEL: begin
            if (pos == POS_W'(0)) e = make_entry(1'b1, 10);
            else if (pos == POS_W'(1)) e = make_entry(1'b0, 60000);
         end
         PAT_FUEL: begin
            if (pos == POS_W'(0)) e = make_entry(1'b1, 10);
            else if (pos == POS_W'(1)) e = make_entry(1'b0, 10);
            else if (pos == POS_W'(2)) e = make_entry(1'b1, 10);
            else if (pos == POS_W'(3)) e = make_entry(1'b0, 60000);
         end
         default: e = ENTRY_END;
      endcase
      return e;
   endfunction

endpackage

FILE: hw/rtl/bapsq_csr.sv
// Configuration registers written through the plain write port.
module bapsq_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [bapsq_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bapsq_pkg::CSR_DATA_W-1:0]      csr_write_data,
   output bapsq_pkg::csr_type                    csr
);

   bapsq_pkg::csr_type csr_ff;
   bapsq_pkg::csr_type csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            bapsq_pkg::CSR_QUIET_START:
               csr_in.quiet_start_minute = csr_write_data[bapsq_pkg::MINUTE_W-1:0];
            bapsq_pkg::CSR_QUIET_END:
               csr_in.quiet_end_minute = csr_write_data[bapsq_pkg::MINUTE_W-1:0];
            bapsq_pkg::CSR_FORCE_MUTE: csr_in.force_mute = csr_write_data[0];
            bapsq_pkg::CSR_ALARM_EN: csr_in.alarm_announce_enable = csr_write_data[0];
            bapsq_pkg::CSR_WARNING_EN: csr_in.warning_announce_enable = csr_write_data[0];
            bapsq_pkg::CSR_TOUCH_EN: csr_in.touch_announce_enable = csr_write_data[0];
            default: csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.quiet_start_minute <= '0;
         csr_ff.quiet_end_minute <= '0;
         csr_ff.force_mute <= 1'b0;
         csr_ff.alarm_announce_enable <= 1'b1;
         csr_ff.warning_announce_enable <= 1'b1;
         csr_ff.touch_announce_enable <= 1'b1;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr = csr_ff;

endmodule

FILE: hw/rtl/bapsq_step.sv
// Sequencer state and the single-pass update for one tick.
module bapsq_step (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step_en,
   input  bapsq_pkg::req_payload_type   item,
   input  bapsq_pkg::csr_type           csr,
   output bapsq_pkg::rsp_payload_type   result
);

   logic                                 sound_ff, sound_in;
   logic [bapsq_pkg::POS_W-1:0]          pos_ff, pos_in;
   logic [bapsq_pkg::COUNTDOWN_BITS-1:0] count_ff, count_in;
   logic                                 pip_ff, pip_in;
   logic                                 drive_ff, drive_in;

   logic                         quiet;
   logic                         msg;
   logic [1:0]                   sel;
   logic [bapsq_pkg::POS_W-1:0]  pos_rd;
   bapsq_pkg::entry_type         entry;

   always_comb begin
      if (csr.quiet_start_minute > csr.quiet_end_minute) begin
         quiet = (item.minute_of_day >= csr.quiet_start_minute)
              || (item.minute_of_day < csr.quiet_end_minute);
      end else begin
         quiet = (item.minute_of_day >= csr.quiet_start_minute)
              && (item.minute_of_day < csr.quiet_end_minute);
      end
   end

   always_comb begin
      pos_rd = (32'(pos_ff) >= bapsq_pkg::PATTERN_LENGTH) ? '0 : pos_ff;
      msg = 1'b0;
      sel = bapsq_pkg::PAT_ALARM;
      if (csr.alarm_announce_enable && item.error_active) begin
         msg = 1'b1;
      end else if (csr.warning_announce_enable && item.level_high_warning) begin
         msg = 1'b1;
         sel = bapsq_pkg::PAT_LEVEL;
      end else if (csr.warning_announce_enable && item.low_fuel_warning) begin
         msg = 1'b1;
         sel = bapsq_pkg::PAT_FUEL;
      end
      entry = bapsq_pkg::pattern_entry(sel, pos_rd);
   end

   always_comb begin
      logic taken;
      taken = 1'b0;
      pos_in = pos_ff;
      pip_in = pip_ff;
      drive_in = drive_ff;
      if (count_ff != '0) begin
         count_in = count_ff - bapsq_pkg::COUNTDOWN_BITS'(1);
      end else begin
         count_in = count_ff;
         drive_in = 1'b0;
      end
      sound_in = item.hundred_ms_tick ? (!csr.force_mute && !quiet) : sound_ff;
      if (sound_in) begin
         if ((count_in == '0) && item.hundred_ms_tick) begin
            if (msg) begin
               taken = 1'b1;
               if (32'(pos_ff) >= bapsq_pkg::PATTERN_LENGTH - 1) pos_in = '0;
               else pos_in = pos_ff + bapsq_pkg::POS_W'(1);
               if (entry.restart) begin
                  pos_in = '0;
               end else begin
                  count_in = entry.ticks;
                  drive_in = entry.drive_on;
               end
            end else begin
               pos_in = '0;
               count_in = '0;
            end
         end
         if (csr.touch_announce_enable && !taken && item.touch_active) begin
            if (!pip_ff) begin
               count_in = bapsq_pkg::PIP_TICKS;
               pip_in = 1'b1;
               drive_in = 1'b1;
            end
         end else begin
            pip_in = 1'b0;
         end
      end else begin
         pos_in = '0;
         count_in = '0;
         drive_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sound_ff <= 1'b0;
         pos_ff <= '0;
         count_ff <= '0;
         pip_ff <= 1'b0;
         drive_ff <= 1'b0;
      end else if (step_en) begin
         sound_ff <= sound_in;
         pos_ff <= pos_in;
         count_ff <= count_in;
         pip_ff <= pip_in;
         drive_ff <= drive_in;
      end
   end

   assign result.buzzer_drive = drive_in;
   assign result.sound_enabled = sound_in;

endmodule

FILE: hw/rtl/buzzer_alarm_pattern_sequencer.sv
// Top level: input register, tick update and result register of the buzzer sequencer.
// An accepted beat passes through the input register and then the result register before
// rsp_valid shows its result; a result not taken can hold the next beat in the input register.
// Throughput: one beat per cycle while rsp_ready is high; req_ready drops only when the
// input and result registers are both full and the result is not taken.
// Reset clears both valid flags, all sequencer state and loads the register reset values.
module buzzer_alarm_pattern_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  bapsq_pkg::req_payload_type          req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output bapsq_pkg::rsp_payload_type          rsp_data,
   input  logic                                csr_write_enable,
   input  logic [bapsq_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bapsq_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   logic                        in_valid_ff, in_valid_in;
   bapsq_pkg::req_payload_type  in_data_ff;
   logic                        out_valid_ff, out_valid_in;
   bapsq_pkg::rsp_payload_type  out_data_ff;
   bapsq_pkg::rsp_payload_type  step_result;
   bapsq_pkg::csr_type          csr;
   logic                        advance;

   assign advance = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   bapsq_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .csr              (csr)
   );

   bapsq_step u_step (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_data_ff),
      .csr     (csr),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= step_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_data_ff;

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the buzzer alarm pattern sequencer with a per-beat predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [bapsq_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LOW = 3'd6;
   localparam logic [bapsq_pkg::CSR_INDEX_W-1:0] CSR_SPARE_HIGH = 3'd7;
   localparam int REQ_W = $bits(bapsq_pkg::req_payload_type);
   localparam int HOLD_OFF_CYCLES = 64;
   localparam int REPORT_LIMIT = 10;
   localparam int DRAIN_GUARD = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   bapsq_pkg::req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   bapsq_pkg::rsp_payload_type rsp_data;
   logic csr_write_enable = 1'b0;
   logic [bapsq_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [bapsq_pkg::CSR_DATA_W-1:0] csr_write_data = '0;

   bapsq_pkg::req_payload_type tick_queue[$];
   bapsq_pkg::rsp_payload_type buzzer_expected[$];
   int sender_idle_pct = 10;
   int receiver_idle_pct = 74;
   int mismatch_count = 0;
   logic hold_go = 1'b0;
   logic hold_done = 1'b0;
   int hold_left = 0;

   bapsq_pkg::csr_type cfg_copy = '{quiet_start_minute: '0, quiet_end_minute: '0,
                                    force_mute: 1'b0, alarm_announce_enable: 1'b1,
                                    warning_announce_enable: 1'b1,
                                    touch_announce_enable: 1'b1};
   logic sound_ok = 1'b0;
   int unsigned step_pos = 0;
   logic [bapsq_pkg::COUNTDOWN_BITS-1:0] countdown = '0;
   logic pip_held = 1'b0;
   logic drive_on = 1'b0;

   int alarm_steps[bapsq_pkg::PATTERN_LENGTH] = '{50, -50, 0, 0, 0, 0, 0, 0, 0, 0};
   int level_steps[bapsq_pkg::PATTERN_LENGTH] = '{10, -60000, 0, 0, 0, 0, 0, 0, 0, 0};
   int fuel_steps[bapsq_pkg::PATTERN_LENGTH] = '{10, -10, 10, -60000, 0, 0, 0, 0, 0, 0};

   int stream_phase = 0;
   int tick_period = 10;
   int stream_minute = 480;
   int touch_left = 0;
   logic err_on = 1'b0;
   logic level_on = 1'b0;
   logic fuel_on = 1'b0;

   buzzer_alarm_pattern_sequencer dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic in_quiet(logic [bapsq_pkg::MINUTE_W-1:0] m);
      if (cfg_copy.quiet_start_minute > cfg_copy.quiet_end_minute)
         return (m >= cfg_copy.quiet_start_minute) || (m < cfg_copy.quiet_end_minute);
      return (m >= cfg_copy.quiet_start_minute) && (m < cfg_copy.quiet_end_minute);
   endfunction

   function automatic bapsq_pkg::rsp_payload_type advance_buzzer(
         bapsq_pkg::req_payload_type t);
      logic took;
      int duration;
      int unsigned idx;
      bapsq_pkg::rsp_payload_type r;
      took = 1'b0;
      duration = 0;
      if (countdown != '0) countdown = countdown - bapsq_pkg::COUNTDOWN_BITS'(1);
      else drive_on = 1'b0;
      if (t.hundred_ms_tick)
         sound_ok = !cfg_copy.force_mute && !in_quiet(t.minute_of_day);
      if (sound_ok) begin
         if (countdown == '0 && t.hundred_ms_tick) begin
            idx = (step_pos >= bapsq_pkg::PATTERN_LENGTH) ? 0 : step_pos;
            if (cfg_copy.alarm_announce_enable && t.error_active) begin
               duration = alarm_steps[idx];
               took = 1'b1;
            end else if (cfg_copy.warning_announce_enable && t.level_high_warning) begin
               duration = level_steps[idx];
               took = 1'b1;
            end else if (cfg_copy.warning_announce_enable && t.low_fuel_warning) begin
               duration = fuel_steps[idx];
               took = 1'b1;
            end
            if (took) begin
               step_pos = (step_pos + 1 > bapsq_pkg::PATTERN_LENGTH - 1) ? 0 : step_pos + 1;
               if (duration > 0) begin
                  countdown = bapsq_pkg::COUNTDOWN_BITS'(duration);
                  drive_on = 1'b1;
               end else if (duration < 0) begin
                  countdown = bapsq_pkg::COUNTDOWN_BITS'(-duration);
                  drive_on = 1'b0;
               end else begin
                  step_pos = 0;
               end
            end else begin
               step_pos = 0;
               countdown = '0;
            end
         end
         if (cfg_copy.touch_announce_enable && !took && t.touch_active) begin
            if (!pip_held) begin
               countdown = bapsq_pkg::PIP_TICKS;
               pip_held = 1'b1;
               drive_on = 1'b1;
            end
         end else begin
            pip_held = 1'b0;
         end
      end else begin
         step_pos = 0;
         countdown = '0;
         drive_on = 1'b0;
      end
      r.buzzer_drive = drive_on;
      r.sound_enabled = sound_ok;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) buzzer_expected.push_back(advance_buzzer(req_data));
         if (!req_valid || req_ready) begin
            if (tick_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= tick_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_go && !hold_done) begin
         hold_left <= HOLD_OFF_CYCLES;
         hold_done <= 1'b1;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   task automatic note_mismatch(string what, int want, int got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("mismatch at %0t ns: %s expected %0d got %0d", $time, what, want, got);
   endtask

   always @(posedge clock) begin : check_results
      bapsq_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (buzzer_expected.size() == 0) begin
            note_mismatch("result beats pending", 0, 1);
         end else begin
            want = buzzer_expected.pop_front();
            if (want.buzzer_drive !== rsp_data.buzzer_drive)
               note_mismatch("buzzer_drive", int'(want.buzzer_drive),
                             int'(rsp_data.buzzer_drive));
            if (want.sound_enabled !== rsp_data.sound_enabled)
               note_mismatch("sound_enabled", int'(want.sound_enabled),
                             int'(rsp_data.sound_enabled));
         end
      end
   end

   task automatic add_tick(logic h, int m, logic e, logic l, logic f, logic t);
      bapsq_pkg::req_payload_type item;
      item.hundred_ms_tick = h;
      item.minute_of_day = bapsq_pkg::MINUTE_W'(m);
      item.error_active = e;
      item.level_high_warning = l;
      item.low_fuel_warning = f;
      item.touch_active = t;
      tick_queue.push_back(item);
   endtask

   task automatic add_stream_items(int count);
      int pick;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 9) == 0) begin
            tick_queue.push_back(bapsq_pkg::req_payload_type'(REQ_W'($urandom)));
         end else begin
            if ($urandom_range(0, 99) == 0) begin
               case ($urandom_range(0, 3))
                  0: tick_period = 1;
                  1: tick_period = 2;
                  2: tick_period = 5;
                  default: tick_period = 10;
               endcase
            end
            stream_phase = (stream_phase + 1) % tick_period;
            if ($urandom_range(0, 39) == 0) err_on = !err_on;
            if ($urandom_range(0, 29) == 0) level_on = !level_on;
            if ($urandom_range(0, 29) == 0) fuel_on = !fuel_on;
            pick = $urandom_range(0, 99);
            if (pick < 3) stream_minute = $urandom_range(0, 1439);
            else if (pick == 3) stream_minute = $urandom_range(1440, 2047);
            else if (pick < 10) stream_minute = (stream_minute + 1) % 1440;
            add_tick(stream_phase == 0, stream_minute, err_on, level_on, fuel_on,
                     touch_left != 0);
            if (touch_left != 0) touch_left--;
            else if ($urandom_range(0, 19) == 0) touch_left = $urandom_range(1, 6);
         end
      end
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      while ((tick_queue.size() != 0 || req_valid || buzzer_expected.size() != 0)
             && guard < DRAIN_GUARD) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [bapsq_pkg::CSR_INDEX_W-1:0] idx,
                            logic [bapsq_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      case (idx)
         bapsq_pkg::CSR_QUIET_START: cfg_copy.quiet_start_minute = value;
         bapsq_pkg::CSR_QUIET_END: cfg_copy.quiet_end_minute = value;
         bapsq_pkg::CSR_FORCE_MUTE: cfg_copy.force_mute = value[0];
         bapsq_pkg::CSR_ALARM_EN: cfg_copy.alarm_announce_enable = value[0];
         bapsq_pkg::CSR_WARNING_EN: cfg_copy.warning_announce_enable = value[0];
         bapsq_pkg::CSR_TOUCH_EN: cfg_copy.touch_announce_enable = value[0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [bapsq_pkg::CSR_DATA_W-1:0] flag_word(logic b);
      return (bapsq_pkg::CSR_DATA_W'($urandom) & ~bapsq_pkg::CSR_DATA_W'(1))
             | bapsq_pkg::CSR_DATA_W'(b);
   endfunction

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      add_tick(1'b0, 0, 1'b0, 1'b0, 1'b0, 1'b1);
      add_tick(1'b1, 0, 1'b0, 1'b0, 1'b0, 1'b1);
      add_tick(1'b0, 0, 1'b0, 1'b0, 1'b0, 1'b1);
      add_tick(1'b1, 1439, 1'b1, 1'b1, 1'b1, 1'b1);
      add_tick(1'b1, 2047, 1'b0, 1'b1, 1'b0, 1'b0);
      add_tick(1'b0, 1024, 1'b0, 1'b0, 1'b0, 1'b1);
      add_tick(1'b1, 512, 1'b0, 1'b0, 1'b0, 1'b0);
      add_tick(1'b1, 256, 1'b0, 1'b0, 1'b0, 1'b0);
      add_tick(1'b1, 2, 1'b0, 1'b0, 1'b0, 1'b0);
      for (int k = 0; k < 12; k++) add_tick(1'b1, 700 + k, 1'b0, 1'b0, 1'b1, k == 5);
      add_tick(1'b1, 128, 1'b0, 1'b1, 1'b0, 1'b0);
      add_tick(1'b1, 64, 1'b0, 1'b0, 1'b0, 1'b1);
      add_tick(1'b0, 1439, 1'b1, 1'b0, 1'b0, 1'b0);
      add_stream_items(250);
      wait_drained();

      write_reg(bapsq_pkg::CSR_QUIET_START, 11'd1320);
      write_reg(bapsq_pkg::CSR_QUIET_END, 11'd360);
      write_reg(bapsq_pkg::CSR_FORCE_MUTE, flag_word(1'b0));
      write_reg(bapsq_pkg::CSR_ALARM_EN, flag_word(1'b1));
      write_reg(bapsq_pkg::CSR_WARNING_EN, flag_word(1'b1));
      write_reg(bapsq_pkg::CSR_TOUCH_EN, flag_word(1'b1));
      add_stream_items(200);
      wait_drained();

      write_reg(bapsq_pkg::CSR_QUIET_START, 11'd1439);
      write_reg(bapsq_pkg::CSR_QUIET_END, 11'd0);
      write_reg(bapsq_pkg::CSR_ALARM_EN, flag_word(1'b0));
      write_reg(bapsq_pkg::CSR_TOUCH_EN, flag_word(1'b0));
      add_stream_items(150);
      wait_drained();

      sender_idle_pct = 74;
      receiver_idle_pct = 10;
      write_reg(bapsq_pkg::CSR_QUIET_START, 11'd600);
      write_reg(bapsq_pkg::CSR_QUIET_END, 11'd660);
      write_reg(bapsq_pkg::CSR_FORCE_MUTE, flag_word(1'b1));
      add_stream_items(100);
      wait_drained();

      write_reg(bapsq_pkg::CSR_FORCE_MUTE, flag_word(1'b0));
      write_reg(bapsq_pkg::CSR_ALARM_EN, flag_word(1'b1));
      write_reg(bapsq_pkg::CSR_TOUCH_EN, flag_word(1'b1));
      write_reg(bapsq_pkg::CSR_WARNING_EN, flag_word(1'b0));
      write_reg(bapsq_pkg::CSR_QUIET_START, 11'd2047);
      write_reg(bapsq_pkg::CSR_QUIET_END, 11'd0);
      write_reg(CSR_SPARE_LOW, bapsq_pkg::CSR_DATA_W'($urandom));
      write_reg(CSR_SPARE_HIGH, bapsq_pkg::CSR_DATA_W'($urandom));
      add_stream_items(150);
      wait_drained();

      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      write_reg(bapsq_pkg::CSR_QUIET_START, 11'd0);
      write_reg(bapsq_pkg::CSR_QUIET_END, 11'd2047);
      write_reg(bapsq_pkg::CSR_WARNING_EN, flag_word(1'b1));
      add_stream_items(50);
      wait_drained();

      write_reg(bapsq_pkg::CSR_QUIET_START, bapsq_pkg::CSR_DATA_W'($urandom_range(0, 2047)));
      write_reg(bapsq_pkg::CSR_QUIET_END, bapsq_pkg::CSR_DATA_W'($urandom_range(0, 2047)));
      write_reg(bapsq_pkg::CSR_FORCE_MUTE, flag_word($urandom_range(0, 3) == 0));
      write_reg(bapsq_pkg::CSR_ALARM_EN, flag_word(1'($urandom_range(0, 1))));
      write_reg(bapsq_pkg::CSR_WARNING_EN, flag_word(1'($urandom_range(0, 1))));
      write_reg(bapsq_pkg::CSR_TOUCH_EN, flag_word(1'($urandom_range(0, 1))));
      add_stream_items(250);
      hold_go = 1'b1;
      wait_drained();

      mismatch_count += buzzer_expected.size();
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/bapsq_pkg.sv
hw/rtl/bapsq_csr.sv
hw/rtl/bapsq_step.sv
hw/rtl/buzzer_alarm_pattern_sequencer.sv
sim/tb_top.sv
